[rtl/pfc_pkg.sv]
package pfc_pkg;

    localparam int LETTER_COUNT = 26;
    localparam int CELL_COUNT   = 25;
    localparam int SIDE         = 5;

    typedef logic [4:0] letter_t;
    typedef logic [4:0] cell_t;
    typedef logic [2:0] coord_t;

    localparam logic [7:0] LETTER_BASE = 8'd97;
    localparam logic [7:0] UPPER_A     = 8'd65;
    localparam logic [7:0] UPPER_Z     = 8'd90;
    localparam logic [7:0] LOWER_Z     = 8'd122;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    localparam letter_t LETTER_I = 5'd8;
    localparam letter_t LETTER_J = 5'd9;
    localparam letter_t LETTER_Z = 5'd25;

    localparam logic REQ_KEY      = 1'b0;
    localparam logic REQ_TEXT     = 1'b1;
    localparam logic MODE_DECRYPT = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic walk;
        logic key_read;
        logic load_out;
    } pfc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic key_walk;
        logic pair;
        logic walk_last;
    } pfc_status_t;

    function automatic coord_t cell_row(input cell_t p);
        coord_t r;
        if (p >= 5'd20) begin
            r = 3'd4;
        end else if (p >= 5'd15) begin
            r = 3'd3;
        end else if (p >= 5'd10) begin
            r = 3'd2;
        end else if (p >= 5'd5) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic cell_t row_base(input coord_t r);
        cell_t b;
        b = ({2'b00, r} << 2) + {2'b00, r};
        return b;
    endfunction

    function automatic coord_t cell_col(input cell_t p);
        cell_t d;
        d = p - row_base(cell_row(p));
        return d[2:0];
    endfunction

    function automatic coord_t step_coord(input coord_t v, input logic decrypt);
        coord_t s;
        if (decrypt == MODE_DECRYPT) begin
            s = (v == 3'd0) ? 3'(SIDE - 1) : v - 3'd1;
        end else begin
            s = (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
        end
        return s;
    endfunction

    function automatic cell_t make_cell(input coord_t r, input coord_t c);
        cell_t p;
        p = row_base(r) + {2'b00, c};
        return p;
    endfunction

endpackage

[rtl/pfc_ctrl.sv]
module pfc_ctrl
    import pfc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  pfc_status_t status_i,
    output pfc_cmd_t    cmd_o
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_POS,
        ST_KEY
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next     = state_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        cmd_o          = '0;
        cmd_o.accept   = s_valid && s_ready;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_o.accept) begin
                    if (status_i.key_walk) begin
                        state_next = ST_WALK;
                    end else if (status_i.pair) begin
                        state_next = ST_POS;
                    end
                end
            end
            ST_WALK: begin
                cmd_o.walk = 1'b1;
                if (status_i.walk_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_POS: begin
                cmd_o.key_read = 1'b1;
                state_next     = ST_KEY;
            end
            ST_KEY: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd_o.load_out = 1'b1;
                    m_valid_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_pair_sequence: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_o.accept && !status_i.key_walk && status_i.pair)
            |=> (state_reg == ST_POS) ##1 (state_reg == ST_KEY))
        else $error("pair did not advance through lookup");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready && state_reg == ST_KEY) |=> (state_reg == ST_KEY))
        else $error("result loaded over a stalled beat");
`endif

endmodule

[rtl/pfc_datapath.sv]
module pfc_datapath
    import pfc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  pfc_cmd_t    cmd_i,
    output pfc_status_t status_o,
    input  logic        cipher_mode,
    input  logic        req_type,
    input  logic [7:0]  char_in,
    input  logic        last_in,
    output logic [6:0]  first_letter,
    output logic [6:0]  second_letter,
    output logic        last_pair
);

    cell_t   letter_position [LETTER_COUNT];
    letter_t key_square      [CELL_COUNT];

    logic [LETTER_COUNT-1:0] letter_used_reg, letter_used_next;
    cell_t   fill_count_reg, fill_count_next;
    logic    key_complete_reg, key_complete_next;
    letter_t held_letter_reg, held_letter_next;
    logic    held_valid_reg, held_valid_next;
    letter_t walk_idx_reg, walk_idx_next;

    cell_t   pos_a_reg, pos_b_reg;
    logic    last_pos_reg, last_key_reg;
    letter_t ks_a_reg, ks_b_reg;
    logic [6:0] first_reg, second_reg;
    logic    last_out_reg;

    logic [7:0] c_low, c_off;
    logic    is_letter, is_key, is_text;
    letter_t l_idx, l_text;
    logic    new_key, used_eff, pair_go, pos_rd_en;
    cell_t   fill_eff;
    logic    place_en;
    letter_t place_idx;
    cell_t   place_cell;
    letter_t pa_addr, pb_addr;
    logic    pair_last;
    coord_t  ra, ca, rb, cb;
    cell_t   na, nb;

    // decode the incoming character
    always_comb begin
        c_low     = (char_in >= UPPER_A && char_in <= UPPER_Z) ? char_in + CASE_OFFSET
                                                               : char_in;
        is_letter = (c_low >= LETTER_BASE) && (c_low <= LOWER_Z);
        c_off     = c_low - LETTER_BASE;
        l_idx     = is_letter ? c_off[4:0] : '0;
        l_text    = (l_idx == LETTER_J) ? LETTER_I : l_idx;
        is_key    = (req_type == REQ_KEY);
        is_text   = (req_type == REQ_TEXT);
        new_key   = cmd_i.accept && is_key && key_complete_reg;
        used_eff  = key_complete_reg ? 1'b0 : letter_used_reg[l_idx];
        fill_eff  = key_complete_reg ? '0 : fill_count_reg;
        pair_go   = (is_letter && held_valid_reg) || (last_in && (is_letter || held_valid_reg));
        pos_rd_en = cmd_i.accept && is_text && key_complete_reg && pair_go;
        pa_addr   = held_valid_reg ? held_letter_reg : l_text;
        pb_addr   = (is_letter && held_valid_reg) ? l_text : LETTER_Z;
        pair_last = (is_letter && held_valid_reg) ? last_in : 1'b1;
    end

    assign status_o.key_walk  = is_key && last_in;
    assign status_o.pair      = is_text && key_complete_reg && pair_go;
    assign status_o.walk_last = (walk_idx_reg == 5'(LETTER_COUNT - 1));

    // one placement per cycle: from a key beat or from the completion walk
    always_comb begin
        place_en   = 1'b0;
        place_idx  = l_idx;
        place_cell = fill_eff;
        if (cmd_i.accept && is_key) begin
            place_en = is_letter && (l_idx != LETTER_J) && !used_eff
                       && (fill_eff < 5'(CELL_COUNT));
        end else if (cmd_i.walk) begin
            place_idx  = walk_idx_reg;
            place_cell = fill_count_reg;
            place_en   = (walk_idx_reg != LETTER_J) && !letter_used_reg[walk_idx_reg]
                         && (fill_count_reg < 5'(CELL_COUNT));
        end
    end

    always_comb begin
        letter_used_next  = new_key ? '0 : letter_used_reg;
        fill_count_next   = new_key ? '0 : fill_count_reg;
        key_complete_next = key_complete_reg;
        held_letter_next  = held_letter_reg;
        held_valid_next   = held_valid_reg;
        walk_idx_next     = walk_idx_reg;
        if (place_en) begin
            letter_used_next[place_idx] = 1'b1;
            fill_count_next             = place_cell + 5'd1;
        end
        if (cmd_i.accept && is_key) begin
            key_complete_next = 1'b0;
            held_valid_next   = 1'b0;
            walk_idx_next     = '0;
        end else if (cmd_i.accept && is_text && key_complete_reg) begin
            if (pair_go) begin
                held_valid_next = 1'b0;
            end else if (is_letter) begin
                held_letter_next = l_text;
                held_valid_next  = 1'b1;
            end
        end
        if (cmd_i.walk) begin
            walk_idx_next = walk_idx_reg + 5'd1;
            if (status_o.walk_last) begin
                key_complete_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            letter_used_reg  <= '0;
            fill_count_reg   <= '0;
            key_complete_reg <= 1'b0;
            held_letter_reg  <= '0;
            held_valid_reg   <= 1'b0;
            walk_idx_reg     <= '0;
        end else begin
            letter_used_reg  <= letter_used_next;
            fill_count_reg   <= fill_count_next;
            key_complete_reg <= key_complete_next;
            held_letter_reg  <= held_letter_next;
            held_valid_reg   <= held_valid_next;
            walk_idx_reg     <= walk_idx_next;
        end
    end

    // position table: one write, two registered reads
    always_ff @(posedge aclk) begin
        if (place_en) begin
            letter_position[place_idx] <= place_cell;
        end
        if (pos_rd_en) begin
            pos_a_reg    <= letter_position[pa_addr];
            pos_b_reg    <= letter_position[pb_addr];
            last_pos_reg <= pair_last;
        end
    end

    // digraph rules on the two cells
    always_comb begin
        ra = cell_row(pos_a_reg);
        ca = cell_col(pos_a_reg);
        rb = cell_row(pos_b_reg);
        cb = cell_col(pos_b_reg);
        if (ra == rb) begin
            na = make_cell(ra, step_coord(ca, cipher_mode));
            nb = make_cell(rb, step_coord(cb, cipher_mode));
        end else if (ca == cb) begin
            na = make_cell(step_coord(ra, cipher_mode), ca);
            nb = make_cell(step_coord(rb, cipher_mode), cb);
        end else begin
            na = make_cell(ra, cb);
            nb = make_cell(rb, ca);
        end
    end

    // key square: one write, two registered reads
    always_ff @(posedge aclk) begin
        if (place_en) begin
            key_square[place_cell] <= place_idx;
        end
        if (cmd_i.key_read) begin
            ks_a_reg     <= key_square[na];
            ks_b_reg     <= key_square[nb];
            last_key_reg <= last_pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.load_out) begin
            first_reg    <= LETTER_BASE[6:0] + {2'b00, ks_a_reg};
            second_reg   <= LETTER_BASE[6:0] + {2'b00, ks_b_reg};
            last_out_reg <= last_key_reg;
        end
    end

    assign first_letter  = first_reg;
    assign second_letter = second_reg;
    assign last_pair     = last_out_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= 5'(CELL_COUNT))
        else $error("key square overfilled");

    a_square_full: assert property (@(posedge aclk) disable iff (!aresetn)
        key_complete_reg |-> (fill_count_reg == 5'(CELL_COUNT)))
        else $error("square marked complete while not full");

    a_held_needs_key: assert property (@(posedge aclk) disable iff (!aresetn)
        !key_complete_reg |-> !held_valid_reg)
        else $error("letter held without a complete key");
`endif

endmodule

[rtl/playfair_digraph_cipher_core.sv]
// Playfair digraph cipher, one ASCII character per input beat.
// Input channel (s_valid/s_ready): s_req_type selects key (0) or text (1),
// s_char_in is the raw byte, s_last_in marks the final key or text character.
// Key beats build the 5x5 square; the last key beat then walks the alphabet
// to fill the unused cells.
// Text beats pair letters; a beat that completes a pair produces one output
// beat (m_valid/m_ready) with both substituted letters and m_last_pair.
// Other beats produce nothing.
// A pair-completing beat passes through the position table read, the key
// square read and the load of the output register; the load waits while
// the output beat is stalled, and no new beat is taken until it is done.
// cfg_wr_en/cfg_wr_data write the mode bit (0 encrypt, 1 decrypt); write it
// only while no pair is in flight.
// Reset (aresetn low, synchronous) clears the square state, the held
// letter and the mode. When the receiver stalls, the output beat holds and
// the block still accepts beats until a new pair needs the output register.
module playfair_digraph_cipher_core
    import pfc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_req_type,
    input  logic [7:0] s_char_in,
    input  logic       s_last_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_first_letter,
    output logic [6:0] m_second_letter,
    output logic       m_last_pair
);

    pfc_cmd_t    cmd;
    pfc_status_t status;
    logic        cipher_mode_reg;

    // mode register: applies from the next pair on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cipher_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            cipher_mode_reg <= cfg_wr_data;
        end
    end

    // sequencing: accept, walk, the two table reads, output load
    pfc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .status_i (status),
        .cmd_o    (cmd)
    );

    // square, tables, pairing and substitution
    pfc_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_i         (cmd),
        .status_o      (status),
        .cipher_mode   (cipher_mode_reg),
        .req_type      (s_req_type),
        .char_in       (s_char_in),
        .last_in       (s_last_in),
        .first_letter  (m_first_letter),
        .second_letter (m_second_letter),
        .last_pair     (m_last_pair)
    );

endmodule
